// ===== sv/tar_walk_pkg.sv =====
// Shared types and constants for the tar archive entry walker.
// Holds header field positions, character codes, result kinds and the walk phase type.
// No dependencies.
package tar_walk_pkg;

   // archive block geometry
   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);
   localparam int unsigned POS_W       = 33;
   localparam int unsigned CMP_W       = 34;

   // header field positions
   localparam logic [IDX_W-1:0] SIZE_FIRST = IDX_W'(124);
   localparam logic [IDX_W-1:0] SIZE_LAST  = IDX_W'(135);
   localparam logic [IDX_W-1:0] TYPE_AT    = IDX_W'(156);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BLOCK_BYTES - 1);

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_DIR   = 8'h35;

   // result queue geometry
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_FILE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_TRUNC = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_SKIP   = 3'b010,
      PH_DONE   = 3'b100
   } walk_phase_type;

   typedef struct packed {
      result_kind_type kind;
      logic [31:0]     header_offset;
      logic [31:0]     name_offset;
      logic [31:0]     data_offset;
      logic [31:0]     size_bytes;
      logic            last_of_run;
   } result_type;

endpackage

// ===== sv/tar_archive_entry_walker_core.sv =====
// Top level of the tar archive entry walker: header parsing, overrun check and result queue.
// Depends on tar_walk_pkg.
//
// The walker takes one archive byte per beat, from offset zero up, and accepts a new byte
// every cycle while req_stall is low. Each byte is folded into the walk state in the cycle
// it is accepted; the results it causes (none, one or two) go into a four-entry result
// queue and leave it one beat per cycle while rsp_stall is low. A byte that ends the header
// of an empty file entry that fits and also ends the walk gives two beats; req_stall rises
// while the queue has fewer than two free entries. After an end or truncation beat, bytes
// are swallowed without results until a byte arrives with req_restart set. csr_write_data
// is the archive size in bytes and should only be written while the walker is idle.
module tar_archive_entry_walker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_header_offset,
   output logic [31:0] rsp_name_offset,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_size_bytes,
   output logic        rsp_last_of_run
);

   localparam int unsigned IDX_W = tar_walk_pkg::IDX_W;
   localparam int unsigned POS_W = tar_walk_pkg::POS_W;
   localparam int unsigned CMP_W = tar_walk_pkg::CMP_W;
   localparam int unsigned PTR_W = tar_walk_pkg::RSP_PTR_W;
   localparam int unsigned CNT_W = tar_walk_pkg::RSP_CNT_W;
   localparam logic [POS_W-1:0] BLOCK_MASK = POS_W'(tar_walk_pkg::BLOCK_BYTES - 1);

   // configuration
   logic [31:0] archive_size_ff;

   // walk state
   tar_walk_pkg::walk_phase_type phase_ff, phase_in, eff_phase;
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in, eff_pos;
   logic [31:0]      entry_start_ff, entry_start_in, eff_start;
   logic [IDX_W-1:0] hdr_idx_ff, hdr_idx_in, eff_idx;
   logic             any_nz_ff, any_nz_in, eff_any_nz;
   logic [31:0]      octal_ff, octal_in, eff_octal;
   logic             oct_stop_ff, oct_stop_in, eff_oct_stop;
   logic [7:0]       entry_type_ff, entry_type_in, eff_type;
   logic             dot_first_ff, dot_first_in, eff_dot_first;
   logic             dot_slash_ff, dot_slash_in, eff_dot_slash;
   logic [POS_W-1:0] skip_ff, skip_in, eff_skip;

   // results of the current byte
   tar_walk_pkg::result_type res0, res1, end_res, entry_res;
   logic [1:0]       res_cnt;
   logic [POS_W-1:0] rounded;
   logic [CMP_W-1:0] archive_cmp;
   logic [7:0]       b;

   // result queue
   tar_walk_pkg::result_type rsp_q_ff [tar_walk_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             req_accept, rsp_pop;
   logic [1:0]       push_cnt;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign b           = req_data_byte;
   assign archive_cmp = CMP_W'(archive_size_ff);

   // state seen by this byte, after an optional restart
   always_comb begin
      if (req_restart) begin
         eff_phase     = tar_walk_pkg::PH_HEADER;
         eff_pos       = '0;
         eff_start     = '0;
         eff_idx       = '0;
         eff_any_nz    = 1'b0;
         eff_octal     = '0;
         eff_oct_stop  = 1'b0;
         eff_type      = '0;
         eff_dot_first = 1'b0;
         eff_dot_slash = 1'b0;
         eff_skip      = '0;
      end else begin
         eff_phase     = phase_ff;
         eff_pos       = byte_pos_ff;
         eff_start     = entry_start_ff;
         eff_idx       = hdr_idx_ff;
         eff_any_nz    = any_nz_ff;
         eff_octal     = octal_ff;
         eff_oct_stop  = oct_stop_ff;
         eff_type      = entry_type_ff;
         eff_dot_first = dot_first_ff;
         eff_dot_slash = dot_slash_ff;
         eff_skip      = skip_ff;
      end
   end

   // per-byte walk update
   always_comb begin
      phase_in       = eff_phase;
      byte_pos_in    = eff_pos;
      entry_start_in = eff_start;
      hdr_idx_in     = eff_idx;
      any_nz_in      = eff_any_nz;
      octal_in       = eff_octal;
      oct_stop_in    = eff_oct_stop;
      entry_type_in  = eff_type;
      dot_first_in   = eff_dot_first;
      dot_slash_in   = eff_dot_slash;
      skip_in        = eff_skip;
      res_cnt        = 2'd0;
      rounded        = '0;

      end_res               = '0;
      end_res.kind          = tar_walk_pkg::KIND_END;
      entry_res             = '0;
      entry_res.kind        = tar_walk_pkg::KIND_FILE;

      unique case (eff_phase)
         tar_walk_pkg::PH_HEADER: begin
            if ((eff_idx == '0) &&
                (CMP_W'(eff_pos) + CMP_W'(tar_walk_pkg::BLOCK_BYTES) > archive_cmp)) begin
               // too little left for another header
               res_cnt  = 2'd1;
               phase_in = tar_walk_pkg::PH_DONE;
            end else begin
               if (eff_idx == '0) begin
                  entry_start_in = eff_pos[31:0];
                  any_nz_in      = 1'b0;
                  octal_in       = '0;
                  oct_stop_in    = 1'b0;
                  entry_type_in  = '0;
                  dot_first_in   = 1'b0;
                  dot_slash_in   = 1'b0;
               end
               if (b != tar_walk_pkg::CHAR_NUL) begin
                  any_nz_in = 1'b1;
               end
               // leading "./" in the name
               if (eff_idx == '0) begin
                  dot_first_in = (b == tar_walk_pkg::CHAR_DOT);
               end else if (eff_idx == IDX_W'(1)) begin
                  dot_slash_in = dot_first_in && (b == tar_walk_pkg::CHAR_SLASH);
               end
               // octal size field: NUL and space skipped, first character outside 0-7 stops
               if ((eff_idx >= tar_walk_pkg::SIZE_FIRST) && (eff_idx <= tar_walk_pkg::SIZE_LAST)
                   && !oct_stop_in && (b != tar_walk_pkg::CHAR_NUL)
                   && (b != tar_walk_pkg::CHAR_SPACE)) begin
                  if ((b < tar_walk_pkg::CHAR_ZERO) || (b > tar_walk_pkg::CHAR_SEVEN)) begin
                     oct_stop_in = 1'b1;
                  end else begin
                     octal_in = {octal_in[28:0], b[2:0]};
                  end
               end
               if (eff_idx == tar_walk_pkg::TYPE_AT) begin
                  entry_type_in = b;
               end
               byte_pos_in = eff_pos + POS_W'(1);
               hdr_idx_in  = eff_idx + IDX_W'(1);

               // end of header block
               rounded = (POS_W'(octal_in) + BLOCK_MASK) & ~BLOCK_MASK;
               entry_res.header_offset = entry_start_in;
               entry_res.name_offset   = entry_start_in + (dot_slash_in ? 32'd2 : 32'd0);
               entry_res.data_offset   = entry_start_in + 32'(tar_walk_pkg::BLOCK_BYTES);
               entry_res.size_bytes    = octal_in;
               if (eff_idx == tar_walk_pkg::LAST_IDX) begin
                  if (!any_nz_in) begin
                     res_cnt  = 2'd1;
                     phase_in = tar_walk_pkg::PH_DONE;
                  end else if (CMP_W'(entry_start_in) + CMP_W'(tar_walk_pkg::BLOCK_BYTES)
                               + CMP_W'(rounded) > archive_cmp) begin
                     entry_res.kind = tar_walk_pkg::KIND_TRUNC;
                     res_cnt        = 2'd1;
                     phase_in       = tar_walk_pkg::PH_DONE;
                  end else begin
                     if (entry_type_in != tar_walk_pkg::CHAR_DIR) begin
                        res_cnt = 2'd1;
                     end
                     if (rounded != '0) begin
                        phase_in = tar_walk_pkg::PH_SKIP;
                        skip_in  = rounded;
                     end else if (CMP_W'(byte_pos_in) + CMP_W'(tar_walk_pkg::BLOCK_BYTES)
                                  > archive_cmp) begin
                        res_cnt  = res_cnt + 2'd1;
                        phase_in = tar_walk_pkg::PH_DONE;
                     end
                  end
               end
            end
         end
         tar_walk_pkg::PH_SKIP: begin
            byte_pos_in = eff_pos + POS_W'(1);
            skip_in     = (eff_skip != '0) ? eff_skip - POS_W'(1) : '0;
            if (skip_in == '0) begin
               phase_in   = tar_walk_pkg::PH_HEADER;
               hdr_idx_in = '0;
               if (CMP_W'(byte_pos_in) + CMP_W'(tar_walk_pkg::BLOCK_BYTES) > archive_cmp) begin
                  res_cnt  = 2'd1;
                  phase_in = tar_walk_pkg::PH_DONE;
               end
            end
         end
         tar_walk_pkg::PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // order the beats: an entry or error first, a walk end in the following slot
   always_comb begin
      if ((eff_phase == tar_walk_pkg::PH_HEADER) && (eff_idx == tar_walk_pkg::LAST_IDX)
          && any_nz_in && (res_cnt != 2'd0) && (phase_in != tar_walk_pkg::PH_DONE
          || entry_res.kind == tar_walk_pkg::KIND_TRUNC || res_cnt == 2'd2)) begin
         res0 = entry_res;
      end else begin
         res0 = end_res;
      end
      res1             = end_res;
      res0.last_of_run = (res_cnt == 2'd1);
      res1.last_of_run = 1'b1;
   end

   assign push_cnt = req_accept ? res_cnt : 2'd0;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         archive_size_ff <= '0;
      end else if (csr_write_en) begin
         archive_size_ff <= csr_write_data;
      end
   end

   // walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tar_walk_pkg::PH_HEADER;
         byte_pos_ff    <= '0;
         entry_start_ff <= '0;
         hdr_idx_ff     <= '0;
         any_nz_ff      <= 1'b0;
         octal_ff       <= '0;
         oct_stop_ff    <= 1'b0;
         entry_type_ff  <= '0;
         dot_first_ff   <= 1'b0;
         dot_slash_ff   <= 1'b0;
         skip_ff        <= '0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         byte_pos_ff    <= byte_pos_in;
         entry_start_ff <= entry_start_in;
         hdr_idx_ff     <= hdr_idx_in;
         any_nz_ff      <= any_nz_in;
         octal_ff       <= octal_in;
         oct_stop_ff    <= oct_stop_in;
         entry_type_ff  <= entry_type_in;
         dot_first_ff   <= dot_first_in;
         dot_slash_ff   <= dot_slash_in;
         skip_ff        <= skip_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         rsp_q_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         rsp_q_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(rsp_pop);
         count_ff  <= count_ff + CNT_W'(push_cnt) - CNT_W'(rsp_pop);
      end
   end

   // room for two beats is needed before a byte is taken
   assign req_stall = (count_ff > CNT_W'(tar_walk_pkg::RSP_DEPTH - 2));

   assign rsp_valid         = (count_ff != '0);
   assign rsp_result_kind   = rsp_q_ff[rd_ptr_ff].kind;
   assign rsp_header_offset = rsp_q_ff[rd_ptr_ff].header_offset;
   assign rsp_name_offset   = rsp_q_ff[rd_ptr_ff].name_offset;
   assign rsp_data_offset   = rsp_q_ff[rd_ptr_ff].data_offset;
   assign rsp_size_bytes    = rsp_q_ff[rd_ptr_ff].size_bytes;
   assign rsp_last_of_run   = rsp_q_ff[rd_ptr_ff].last_of_run;

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(tar_walk_pkg::RSP_DEPTH))
      else $error("result queue overfilled");

   // a skip in progress always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tar_walk_pkg::PH_SKIP) |-> (skip_ff != '0))
      else $error("skip phase with nothing to skip");

   // inside a header the position tracks the header start plus index
   assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == tar_walk_pkg::PH_HEADER) && (hdr_idx_ff != '0))
         |-> (byte_pos_ff[31:0] == entry_start_ff + 32'(hdr_idx_ff)))
      else $error("header index out of step with byte position");

   // a finished walk adds no beats until restarted
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (phase_ff == tar_walk_pkg::PH_DONE) && !req_restart)
         |=> (count_ff <= $past(count_ff)))
      else $error("result after end of walk");

endmodule

// ===== tb/tar_archive_entry_walker_core_tb.sv =====
// Self-checking bench for tar_archive_entry_walker_core: streams ustar images byte by byte
// and checks every report beat against an in-bench model of the header walk.
// Depends on tar_walk_pkg and the walker RTL.
module tar_archive_entry_walker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BLOCK_BYTES = tar_walk_pkg::BLOCK_BYTES;

   // data bytes actually sent per entry; larger sizes leave the walk in its skip phase
   localparam int MAX_SKIP_SENT = 2500;

   typedef enum {RX_FREE, RX_SPARSE, RX_HALF, RX_RUNS} rx_pattern_type;
   typedef enum {TAIL_ZERO_BLOCK, TAIL_SHORT, TAIL_CUT, TAIL_ANY_SIZE} archive_tail_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_header_offset;
   logic [31:0] rsp_name_offset;
   logic [31:0] rsp_data_offset;
   logic [31:0] rsp_size_bytes;
   logic        rsp_last_of_run;

   tar_archive_entry_walker_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_header_offset (rsp_header_offset),
      .rsp_name_offset   (rsp_name_offset),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_size_bytes    (rsp_size_bytes),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Walk model: state mirrors the walker, reports go to the expected-report queue
   // ---------------------------------------------------------------------------------------
   logic [31:0]                  archive_bytes = '0;
   tar_walk_pkg::walk_phase_type cur_phase;
   logic [32:0]                  stream_pos;
   logic [31:0]                  hdr_base;
   int unsigned                  hdr_count;
   logic                         hdr_nonzero;
   logic [31:0]                  size_acc;
   logic                         size_done;
   logic [7:0]                   type_char;
   logic                         lead_dot;
   logic                         lead_dot_slash;
   logic [32:0]                  data_left;

   tar_walk_pkg::result_type walk_reports[$];
   tar_walk_pkg::result_type byte_reports[2];
   int                       byte_report_n;
   int                       report_total = 0;
   int                       accepted_bytes = 0;
   int                       mismatch_count = 0;

   function automatic void clear_walk();
      cur_phase      = tar_walk_pkg::PH_HEADER;
      stream_pos     = '0;
      hdr_base       = '0;
      hdr_count      = 0;
      hdr_nonzero    = 1'b0;
      size_acc       = '0;
      size_done      = 1'b0;
      type_char      = '0;
      lead_dot       = 1'b0;
      lead_dot_slash = 1'b0;
      data_left      = '0;
   endfunction

   function automatic void add_report(tar_walk_pkg::result_kind_type kind, logic [31:0] hdr,
                                      logic [31:0] name, logic [31:0] data, logic [31:0] size);
      byte_reports[byte_report_n] = '{kind, hdr, name, data, size, 1'b0};
      byte_report_n++;
   endfunction

   // a header may start only with a whole block left before the archive end
   function automatic logic header_fits();
      return 64'(stream_pos) + 64'(BLOCK_BYTES) <= 64'(archive_bytes);
   endfunction

   function automatic void begin_header();
      cur_phase = tar_walk_pkg::PH_HEADER;
      hdr_count = 0;
      if (!header_fits()) begin
         add_report(tar_walk_pkg::KIND_END, '0, '0, '0, '0);
         cur_phase = tar_walk_pkg::PH_DONE;
      end
   endfunction

   function automatic void take_header_byte(logic [7:0] b);
      if (b != tar_walk_pkg::CHAR_NUL) hdr_nonzero = 1'b1;
      if (hdr_count == 0) lead_dot = (b == tar_walk_pkg::CHAR_DOT);
      else if (hdr_count == 1) lead_dot_slash = lead_dot && (b == tar_walk_pkg::CHAR_SLASH);
      // octal size: NUL and space skipped, first other character outside 0-7 freezes the value
      if (hdr_count >= tar_walk_pkg::SIZE_FIRST && hdr_count <= tar_walk_pkg::SIZE_LAST &&
          !size_done && b != tar_walk_pkg::CHAR_NUL && b != tar_walk_pkg::CHAR_SPACE) begin
         if (b < tar_walk_pkg::CHAR_ZERO || b > tar_walk_pkg::CHAR_SEVEN) size_done = 1'b1;
         else size_acc = (size_acc << 3) + 32'(b - tar_walk_pkg::CHAR_ZERO);
      end
      if (hdr_count == tar_walk_pkg::TYPE_AT) type_char = b;
   endfunction

   function automatic void close_header();
      logic [63:0] rounded;
      logic [31:0] name_at;
      hdr_count = 0;
      rounded = (64'(size_acc) + 64'(BLOCK_BYTES - 1)) & ~64'(BLOCK_BYTES - 1);
      name_at = hdr_base + (lead_dot_slash ? 32'd2 : 32'd0);
      if (!hdr_nonzero) begin
         add_report(tar_walk_pkg::KIND_END, '0, '0, '0, '0);
         cur_phase = tar_walk_pkg::PH_DONE;
      end else if (64'(hdr_base) + 64'(BLOCK_BYTES) + rounded > 64'(archive_bytes)) begin
         // overrun compared in full width, no wrap
         add_report(tar_walk_pkg::KIND_TRUNC, hdr_base, name_at, hdr_base + BLOCK_BYTES,
                    size_acc);
         cur_phase = tar_walk_pkg::PH_DONE;
      end else begin
         if (type_char != tar_walk_pkg::CHAR_DIR)
            add_report(tar_walk_pkg::KIND_FILE, hdr_base, name_at, hdr_base + BLOCK_BYTES,
                       size_acc);
         if (rounded != 0) begin
            cur_phase = tar_walk_pkg::PH_SKIP;
            data_left = rounded[32:0];
         end else begin
            begin_header();
         end
      end
   endfunction

   function automatic void walk_archive_byte(logic [7:0] b, logic rst);
      byte_report_n = 0;
      if (rst) clear_walk();
      case (cur_phase)
         tar_walk_pkg::PH_HEADER: begin
            if (hdr_count == 0 && !header_fits()) begin
               add_report(tar_walk_pkg::KIND_END, '0, '0, '0, '0);
               cur_phase = tar_walk_pkg::PH_DONE;
            end else begin
               if (hdr_count == 0) begin
                  hdr_base       = stream_pos[31:0];
                  hdr_nonzero    = 1'b0;
                  size_acc       = '0;
                  size_done      = 1'b0;
                  type_char      = '0;
                  lead_dot       = 1'b0;
                  lead_dot_slash = 1'b0;
               end
               take_header_byte(b);
               stream_pos = stream_pos + 33'd1;
               hdr_count++;
               if (hdr_count >= BLOCK_BYTES) close_header();
            end
         end
         tar_walk_pkg::PH_SKIP: begin
            stream_pos = stream_pos + 33'd1;
            if (data_left != 0) data_left = data_left - 33'd1;
            if (data_left == 0) begin_header();
         end
         default: ;
      endcase
      if (byte_report_n > 0) byte_reports[byte_report_n - 1].last_of_run = 1'b1;
      for (int i = 0; i < byte_report_n; i++) walk_reports.push_back(byte_reports[i]);
      report_total += byte_report_n;
   endfunction

   initial clear_walk();

   // ---------------------------------------------------------------------------------------
   // Report checker
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tar_walk_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (walk_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: report beat with none expected, actual kind %0d header_offset %h",
                     $time, rsp_result_kind, rsp_header_offset);
         end else begin
            want = walk_reports.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
            check_field("header_offset", want.header_offset, rsp_header_offset);
            check_field("name_offset", want.name_offset, rsp_name_offset);
            check_field("data_offset", want.data_offset, rsp_data_offset);
            check_field("size_bytes", want.size_bytes, rsp_size_bytes);
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Report-side stall: a randomly chosen pattern, redrawn whenever its run ends
   // ---------------------------------------------------------------------------------------
   rx_pattern_type rx_pattern = RX_FREE;
   int             rx_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            rx_left    = $urandom_range(32, 300);
         end
         rx_left--;
         case (rx_pattern)
            RX_FREE:   rsp_stall <= 1'b0;
            RX_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
            RX_HALF:   rsp_stall <= 1'($urandom_range(0, 1));
            default:   rsp_stall <= (rx_left % 16) < 5;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Byte sender: bursts of random length with random gaps
   // ---------------------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_byte(logic [7:0] b, logic rst);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 2) == 0) begin
            req_valid     <= 1'b0;
            req_data_byte <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_restart   <= rst;
      do @(posedge clock); while (req_stall);
      accepted_bytes++;
      walk_archive_byte(b, rst);
   endtask

   // wait until every expected report is out and the walker has settled
   task automatic drain_walker();
      req_valid <= 1'b0;
      while (walk_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_archive_size(logic [31:0] v);
      drain_walker();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      archive_bytes = v;
      csr_write_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Archive building
   // ---------------------------------------------------------------------------------------
   logic [7:0] hdr_block [BLOCK_BYTES];

   task automatic clear_block();
      for (int i = 0; i < BLOCK_BYTES; i++) hdr_block[i] = tar_walk_pkg::CHAR_NUL;
   endtask

   // octal digits right-aligned in the size field, leading zeros replaced by pad
   task automatic put_size_octal(logic [31:0] v, logic [7:0] pad, logic [7:0] term);
      logic [2:0] digit;
      logic       lead;
      lead = 1'b1;
      for (int i = 10; i >= 0; i--) begin
         digit = 3'(v >> (3 * i));
         if (digit != 0 || i == 0) lead = 1'b0;
         hdr_block[tar_walk_pkg::SIZE_LAST - 1 - i] =
            lead ? pad : tar_walk_pkg::CHAR_ZERO + 8'(digit);
      end
      hdr_block[tar_walk_pkg::SIZE_LAST] = term;
   endtask

   task automatic put_size_text(string t);
      for (int i = 0; i < 12; i++)
         hdr_block[tar_walk_pkg::SIZE_FIRST + i] = (i < t.len()) ? t[i] : tar_walk_pkg::CHAR_NUL;
   endtask

   task automatic fill_header(logic dot_slash, logic [7:0] kind_char, logic [31:0] size);
      for (int i = 0; i < BLOCK_BYTES; i++) hdr_block[i] = 8'($urandom_range(0, 255));
      if (dot_slash) begin
         hdr_block[0] = tar_walk_pkg::CHAR_DOT;
         hdr_block[1] = tar_walk_pkg::CHAR_SLASH;
      end else begin
         hdr_block[0] = 8'h61 + 8'($urandom_range(0, 25));
      end
      case ($urandom_range(0, 7))
         5:       put_size_octal(size, tar_walk_pkg::CHAR_ZERO, tar_walk_pkg::CHAR_SPACE);
         6:       put_size_octal(size, tar_walk_pkg::CHAR_SPACE, tar_walk_pkg::CHAR_NUL);
         7:       put_size_octal(size, tar_walk_pkg::CHAR_NUL, tar_walk_pkg::CHAR_SPACE);
         default: put_size_octal(size, tar_walk_pkg::CHAR_ZERO, tar_walk_pkg::CHAR_NUL);
      endcase
      hdr_block[tar_walk_pkg::TYPE_AT] = kind_char;
   endtask

   task automatic send_block(logic rst_first, int count);
      for (int i = 0; i < count; i++) send_byte(hdr_block[i], rst_first && i == 0);
   endtask

   task automatic send_data(int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   function automatic logic [63:0] round_up(logic [31:0] v);
      return (64'(v) + 64'(BLOCK_BYTES - 1)) & ~64'(BLOCK_BYTES - 1);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------------------

   // less than one block in the archive: the first byte ends the walk, later bytes ignored
   task automatic test_short_archives();
      set_archive_size(32'd0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_data(3);
      set_archive_size(32'd511);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_data(2);
   endtask

   // a header with only its last byte set is an entry; an all-zero header ends the walk
   task automatic test_zero_header();
      set_archive_size(32'd1024);
      clear_block();
      hdr_block[BLOCK_BYTES - 1] = 8'h80;
      send_block(1'b1, BLOCK_BYTES);
      clear_block();
      send_block(1'b0, BLOCK_BYTES);
      send_data(3);
   endtask

   // "./" file, then an empty file ending exactly at the archive end: file and end together
   task automatic test_file_entries();
      set_archive_size(32'd1536);
      fill_header(1'b1, tar_walk_pkg::CHAR_ZERO, 32'd100);
      send_block(1'b1, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      fill_header(1'b0, tar_walk_pkg::CHAR_ZERO, 32'd0);
      send_block(1'b0, BLOCK_BYTES);
      send_data(4);
   endtask

   // directories report nothing but their data is still skipped
   task automatic test_directory_entries();
      set_archive_size(32'd2560);
      fill_header(1'b1, tar_walk_pkg::CHAR_DIR, 32'd512);
      send_block(1'b1, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      fill_header(1'b0, tar_walk_pkg::CHAR_DIR, 32'd0);
      send_block(1'b0, BLOCK_BYTES);
      clear_block();
      send_block(1'b0, BLOCK_BYTES);
   endtask

   task automatic test_truncation();
      // one byte too many for the archive
      set_archive_size(32'd1024);
      fill_header(1'b0, tar_walk_pkg::CHAR_ZERO, 32'd513);
      send_block(1'b1, BLOCK_BYTES);
      send_data(20);
      // exact fit: the end comes from the last data byte
      fill_header(1'b1, tar_walk_pkg::CHAR_ZERO, 32'd512);
      send_block(1'b1, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      // largest size rounds past 32 bits and must not wrap into a fit
      set_archive_size(32'hFFFF_FFFF);
      fill_header(1'b1, tar_walk_pkg::CHAR_ZERO, 32'hFFFF_FFFF);
      send_block(1'b1, BLOCK_BYTES);
      send_data(8);
   endtask

   task automatic test_size_field_parsing();
      set_archive_size(32'hFFFF_FFFF);
      // spaces and a NUL between digits are skipped
      fill_header(1'b1, tar_walk_pkg::CHAR_ZERO, 32'd0);
      put_size_text("  1 7 3     ");
      hdr_block[tar_walk_pkg::SIZE_FIRST + 3] = tar_walk_pkg::CHAR_NUL;
      send_block(1'b1, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      // twelve digits wrap modulo 2^32; dot without slash keeps the name at the header
      fill_header(1'b0, tar_walk_pkg::CHAR_NUL, 32'd0);
      put_size_text("400000000012");
      hdr_block[0] = tar_walk_pkg::CHAR_DOT;
      hdr_block[1] = "x";
      send_block(1'b0, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      // a digit above seven stops parsing; slash without a leading dot
      fill_header(1'b0, "x", 32'd0);
      put_size_text("0017819     ");
      hdr_block[1] = tar_walk_pkg::CHAR_SLASH;
      send_block(1'b0, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      // a character below zero stops parsing too
      fill_header(1'b0, tar_walk_pkg::CHAR_DIR, 32'd0);
      put_size_text("  12/7      ");
      send_block(1'b0, BLOCK_BYTES);
      send_data(BLOCK_BYTES);
      clear_block();
      send_block(1'b0, BLOCK_BYTES);
   endtask

   // restart in the middle of a header and in the middle of a data skip
   task automatic test_restart_mid_walk();
      set_archive_size(32'd4096);
      fill_header(1'b0, tar_walk_pkg::CHAR_ZERO, 32'd700);
      send_block(1'b1, 200);
      fill_header(1'b1, tar_walk_pkg::CHAR_ZERO, 32'd1000);
      send_block(1'b1, BLOCK_BYTES);
      send_data(300);
      fill_header(1'b0, tar_walk_pkg::CHAR_NUL, 32'd0);
      send_block(1'b1, BLOCK_BYTES);
      clear_block();
      send_block(1'b0, BLOCK_BYTES);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random archives
   // ---------------------------------------------------------------------------------------
   function automatic logic [31:0] pick_file_size();
      case ($urandom_range(0, 19))
         0, 1, 2:    return 32'd0;
         15, 16, 17: return $urandom_range(601, 2000);
         18:         return BLOCK_BYTES * $urandom_range(1, 3);
         19:         return $urandom;
         default:    return $urandom_range(1, 600);
      endcase
   endfunction

   function automatic logic [7:0] pick_type_char();
      case ($urandom_range(0, 19))
         0, 1, 2: return tar_walk_pkg::CHAR_DIR;
         3, 4:    return tar_walk_pkg::CHAR_NUL;
         5, 6:    return 8'($urandom_range(0, 255));
         default: return tar_walk_pkg::CHAR_ZERO;
      endcase
   endfunction

   task automatic run_random_archive();
      logic [31:0]      sizes [3];
      logic [7:0]       kinds [3];
      int               n_ent;
      int               abort_at;
      int               data_n;
      logic [63:0]      total;
      logic [63:0]      arch;
      archive_tail_type tail;
      n_ent = $urandom_range(1, 3);
      total = '0;
      for (int e = 0; e < n_ent; e++) begin
         sizes[e] = pick_file_size();
         kinds[e] = pick_type_char();
         total += 64'(BLOCK_BYTES) + round_up(sizes[e]);
      end
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: tail = TAIL_ZERO_BLOCK;
         5, 6:          tail = TAIL_SHORT;
         7, 8:          tail = TAIL_CUT;
         default:       tail = TAIL_ANY_SIZE;
      endcase
      case (tail)
         TAIL_ZERO_BLOCK: arch = total + 64'd1024 + 64'($urandom_range(0, 700));
         TAIL_SHORT:      arch = total + 64'($urandom_range(0, 511));
         TAIL_CUT:        arch = 64'($urandom_range(0, 32'(total)));
         default:         arch = 64'($urandom);
      endcase
      if (arch > 64'hFFFF_FFFF) arch = 64'hFFFF_FFFF;
      // mostly a fresh size; sometimes the walk restarts under the old one
      if ($urandom_range(0, 4) != 0) set_archive_size(arch[31:0]);

      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ent - 1) : -1;
      for (int e = 0; e < n_ent; e++) begin
         if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < BLOCK_BYTES; i++) hdr_block[i] = 8'($urandom_range(0, 255));
         end else begin
            fill_header(1'($urandom_range(0, 1)), kinds[e], sizes[e]);
         end
         if (e == abort_at && $urandom_range(0, 1) == 1) begin
            send_block(e == 0, $urandom_range(1, BLOCK_BYTES - 1));
            return;
         end
         send_block(e == 0, BLOCK_BYTES);
         data_n = (round_up(sizes[e]) > MAX_SKIP_SENT) ? MAX_SKIP_SENT : int'(round_up(sizes[e]));
         if (e == abort_at) begin
            send_data($urandom_range(0, data_n));
            return;
         end
         send_data(data_n);
      end
      if (tail == TAIL_ZERO_BLOCK || tail == TAIL_ANY_SIZE) begin
         clear_block();
         send_block(1'b0, BLOCK_BYTES);
      end
      send_data($urandom_range(0, 6));
   endtask

   task automatic test_random_walks();
      int first_report;
      int first_byte;
      first_report = report_total;
      first_byte   = accepted_bytes;
      while (report_total - first_report < 60 || accepted_bytes - first_byte < 950)
         run_random_archive();
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_archives();
      test_zero_header();
      test_file_entries();
      test_directory_entries();
      test_truncation();
      test_size_field_parsing();
      test_restart_mid_walk();
      test_random_walks();
      drain_walker();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== tar_archive_entry_walker_core.f =====
sv/tar_walk_pkg.sv
sv/tar_archive_entry_walker_core.sv
tb/tar_archive_entry_walker_core_tb.sv
